>>> rtl/cbml_pkg.sv
// package for the capacity checked best move list
// holds the payload structs, command and register codes, state type and sizes
// used by the top level and by its port checker
`default_nettype none

package cbml_pkg;

   // number of target slots in the list
   localparam int NumSlots = 4;
   localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
   localparam int CountW   = $clog2(NumSlots + 1);

   // configuration port sizes
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 31;
   localparam int SlotsCfgW = 3;
   localparam int WeightW  = 31;

   localparam logic [SlotsCfgW-1:0] SLOTS_RESET = 3'd4;
   localparam logic [WeightW-1:0]   CAP_RESET   = 31'h7FFF_FFFF;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_SLOTS_IN_USE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CAPACITY0    = 3'd1;

   // commands
   localparam logic [1:0] CMD_OFFER = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      WALK,
      READ
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        node_id;
      logic [WeightW-1:0] node_weight;
      logic [15:0]        source_block;
      logic [WeightW-1:0] source_block_weight;
      logic signed [31:0] move_gain;
   } req_type;

   typedef struct packed {
      logic [1:0]         slot_index;
      logic               entry_valid;
      logic [31:0]        entry_node;
      logic [15:0]        entry_source;
      logic signed [31:0] entry_gain;
      logic               last_entry;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        node;
      logic [WeightW-1:0] weight;
      logic [15:0]        source;
      logic signed [31:0] gain;
   } slot_entry_type;

endpackage

`default_nettype wire

>>> rtl/capacity_checked_best_move_list.sv
// Sorted best-move list with one capacity-limited slot per target.
// An item is a command: offer a move, read out the used slots, or clear the list.
// One shared compare unit (gain, node id, capacity) serves every slot under a small
// sequencer. An offer is accepted, compared against the last used slot and, if it gets
// in, walked through the used slots from the first one. A read emits one item per
// cycle for each used slot, slowed only by rsp_stall; a clear or an ignored item is
// done once accepted. No new item is taken while an offer or a read is under way.
// Depends on cbml_pkg.
`default_nettype none

module capacity_checked_best_move_list (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire cbml_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output cbml_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cbml_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [cbml_pkg::CsrDataW-1:0] csr_data
);

   cbml_pkg::state_type state_ff, state_in;

   logic [cbml_pkg::SlotW-1:0] idx_ff, idx_in;

   logic [cbml_pkg::SlotsCfgW-1:0] slots_ff;
   logic [cbml_pkg::WeightW-1:0]   cap_ff [cbml_pkg::NumSlots];

   logic                     slot_valid_ff [cbml_pkg::NumSlots];
   cbml_pkg::slot_entry_type slot_ff       [cbml_pkg::NumSlots];
   cbml_pkg::slot_entry_type carry_ff;

   logic              rsp_valid_ff;
   cbml_pkg::rsp_type rsp_ff;

   logic [cbml_pkg::CountW-1:0]  n_used;
   logic [cbml_pkg::SlotW-1:0]   last_idx;
   logic [cbml_pkg::SlotW-1:0]   cmp_idx;
   logic [cbml_pkg::CsrIdxW-1:0] cap_sel;
   logic                         idx_last;
   logic                         req_accept;
   logic                         offer_go;
   logic                         beats;
   logic                         fits;
   logic                         do_swap;
   logic                         rsp_free;
   logic                         rsp_load;
   logic                         csr_write;

   assign n_used = (slots_ff > cbml_pkg::SlotsCfgW'(cbml_pkg::NumSlots))
                 ? cbml_pkg::CountW'(cbml_pkg::NumSlots)
                 : cbml_pkg::CountW'(slots_ff);
   assign last_idx = cbml_pkg::SlotW'(n_used - cbml_pkg::CountW'(1));
   assign idx_last = (cbml_pkg::CountW'(idx_ff) + cbml_pkg::CountW'(1)) == n_used;

   assign req_accept = req_valid && !req_stall;
   assign offer_go   = (req_data.cmd == cbml_pkg::CMD_OFFER)
                    && (req_data.node_weight != '0)
                    && (req_data.node_weight != req_data.source_block_weight)
                    && (n_used != '0);

   // shared compare unit: last used slot while checking, walk position otherwise
   assign cmp_idx = (state_ff == cbml_pkg::CHECK) ? last_idx : idx_ff;
   assign beats   = !slot_valid_ff[cmp_idx]
                 || ($signed(carry_ff.gain) < $signed(slot_ff[cmp_idx].gain))
                 || (($signed(carry_ff.gain) == $signed(slot_ff[cmp_idx].gain))
                     && (carry_ff.node < slot_ff[cmp_idx].node));
   assign fits    = carry_ff.weight <= cap_ff[cmp_idx];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign csr_write = csr_valid && csr_ready;
   assign cap_sel   = csr_index - cbml_pkg::CSR_CAPACITY0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbml_pkg::IDLE: begin
            if (req_accept) begin
               if (offer_go) begin
                  state_in = cbml_pkg::CHECK;
               end else if (req_data.cmd == cbml_pkg::CMD_READ && n_used != '0) begin
                  state_in = cbml_pkg::READ;
               end
            end
         end
         cbml_pkg::CHECK: begin
            state_in = beats ? cbml_pkg::WALK : cbml_pkg::IDLE;
         end
         cbml_pkg::WALK: begin
            // stop at the end or once an empty entry is carried out
            if (idx_last || (beats && fits && !slot_valid_ff[idx_ff])) begin
               state_in = cbml_pkg::IDLE;
            end
         end
         cbml_pkg::READ: begin
            if (rsp_free && idx_last) begin
               state_in = cbml_pkg::IDLE;
            end
         end
         default: state_in = cbml_pkg::IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      do_swap   = 1'b0;
      rsp_load  = 1'b0;
      idx_in    = idx_ff;
      csr_ready = 1'b1;
      unique case (state_ff)
         cbml_pkg::IDLE: begin
            req_stall = 1'b0;
            idx_in    = '0;
         end
         cbml_pkg::CHECK: begin
            idx_in = '0;
         end
         cbml_pkg::WALK: begin
            do_swap = beats && fits;
            idx_in  = idx_ff + cbml_pkg::SlotW'(1);
         end
         cbml_pkg::READ: begin
            rsp_load = rsp_free;
            if (rsp_free) begin
               idx_in = idx_ff + cbml_pkg::SlotW'(1);
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbml_pkg::IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= cbml_pkg::SLOTS_RESET;
         for (int i = 0; i < cbml_pkg::NumSlots; i++) begin
            cap_ff[i]        <= cbml_pkg::CAP_RESET;
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            if (csr_index == cbml_pkg::CSR_SLOTS_IN_USE) begin
               slots_ff <= csr_data[cbml_pkg::SlotsCfgW-1:0];
            end else if (cap_sel < cbml_pkg::CsrIdxW'(cbml_pkg::NumSlots)) begin
               cap_ff[cbml_pkg::SlotW'(cap_sel)] <= csr_data;
            end
         end
         if (req_accept && req_data.cmd == cbml_pkg::CMD_CLEAR) begin
            for (int i = 0; i < cbml_pkg::NumSlots; i++) begin
               slot_valid_ff[i] <= 1'b0;
            end
         end else if (do_swap) begin
            slot_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // payload: carried move, slot entries, output register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         carry_ff.node   <= req_data.node_id;
         carry_ff.weight <= req_data.node_weight;
         carry_ff.source <= req_data.source_block;
         carry_ff.gain   <= req_data.move_gain;
      end else if (do_swap) begin
         carry_ff <= slot_ff[idx_ff];
      end
      if (do_swap) begin
         slot_ff[idx_ff] <= carry_ff;
      end
      if (rsp_load) begin
         rsp_ff.slot_index   <= 2'(idx_ff);
         rsp_ff.entry_valid  <= slot_valid_ff[idx_ff];
         rsp_ff.entry_node   <= slot_valid_ff[idx_ff] ? slot_ff[idx_ff].node : '0;
         rsp_ff.entry_source <= slot_valid_ff[idx_ff] ? slot_ff[idx_ff].source : '0;
         rsp_ff.entry_gain   <= slot_valid_ff[idx_ff] ? slot_ff[idx_ff].gain : '0;
         rsp_ff.last_entry   <= idx_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/cbml_checker.sv
// port checker for the capacity checked best move list
// watches the top level ports only; attached by the bind at the end of this file
// depends on cbml_pkg
`default_nettype none

module cbml_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire cbml_pkg::rsp_type rsp_data
);

   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   // empty slots report zero payload
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |->
         rsp_data.entry_node == '0 && rsp_data.entry_source == '0
         && rsp_data.entry_gain == '0)
      else $error("empty slot reported with nonzero payload");

   // a read run goes on without a gap, slot by slot
   a_run_next: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_data.last_entry |=>
         rsp_valid && rsp_data.slot_index == $past(rsp_data.slot_index) + 2'd1)
      else $error("read run broken");

   // no new item while a read run is unfinished
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_entry |-> req_stall)
      else $error("item taken during a read run");

endmodule

bind capacity_checked_best_move_list cbml_checker u_cbml_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
